// ===== hw/rtl/pixel_format_to_rgb_unit_defines.svh =====
// Assertion macros for the pixel format converter.
// Each use expects clk and rst_n in scope.
`ifndef PIXEL_FORMAT_TO_RGB_UNIT_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGB_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PFR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfr assertion failed");

// Next-cycle implication.
`define PFR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfr assertion failed");

`endif

// ===== hw/rtl/pfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

    // Palette geometry
    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // Pixel format codes
    localparam logic [1:0] FMT_YCBCR  = 2'd0;
    localparam logic [1:0] FMT_PAL8   = 2'd1;
    localparam logic [1:0] FMT_RGB555 = 2'd2;

    // Item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    // Register map (word index)
    localparam int         CFG_AW         = 4;
    localparam logic [1:0] REG_FORMAT     = 2'd0;
    localparam logic [1:0] REG_VIS_WIDTH  = 2'd1;
    localparam logic [1:0] REG_VIS_HEIGHT = 2'd2;
    localparam logic [1:0] REG_ROW_PITCH  = 2'd3;

    // YCbCr coefficients in thousandths
    localparam logic [10:0] COEF_R_CR  = 11'd1402;
    localparam logic [10:0] COEF_G_CB  = 11'd344;
    localparam logic [10:0] COEF_G_CR  = 11'd714;
    localparam logic [10:0] COEF_B_CB  = 11'd1772;
    localparam logic [8:0]  CHROMA_MID = 9'd128;

    // ceil(2^28 / 1000); exact floor(p / 1000) for p below 2^28 / 544
    localparam logic [18:0] RECIP_1000  = 19'd268436;
    localparam int          RECIP_SHIFT = 28;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [12:0] visible_width;
        logic [12:0] visible_height;
        logic [15:0] row_pitch;
    } cfg_t;

    typedef struct packed {
        logic              wr_en;
        logic [PAL_AW-1:0] wr_slot;
        logic [31:0]       wr_data;
        logic              rd_en;
        logic [PAL_AW-1:0] rd_idx;
    } pal_req_t;

    typedef struct packed {
        logic s1_valid;
        logic s2_valid;
        logic s3_valid;
        logic s4_valid;
    } pipe_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfr_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pfr_pix_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [11:0] col;
    logic [11:0] row_index;
    logic [7:0]  luma;
    logic [7:0]  chroma_blue;
    logic [7:0]  chroma_red;
    logic [7:0]  color_index;
    logic [15:0] packed_555;
    logic [7:0]  palette_slot;
    logic [31:0] palette_value;

    modport source (
        output valid, cmd, col, row_index, luma, chroma_blue, chroma_red,
               color_index, packed_555, palette_slot, palette_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, col, row_index, luma, chroma_blue, chroma_red,
               color_index, packed_555, palette_slot, palette_value,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pfr_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pfr_res_if;
    logic        valid;
    logic        ready;
    logic [27:0] dest_address;
    logic [31:0] rgb_word;

    modport source (
        output valid, dest_address, rgb_word,
        input  ready
    );

    modport sink (
        input  valid, dest_address, rgb_word,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/pfr_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfr_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output pfr_pkg::cfg_t                   cfg
);

    pfr_pkg::cfg_t cfg_reg;
    pfr_pkg::cfg_t cfg_next;
    logic          wr_strobe;
    logic [1:0]    reg_sel;

    assign wr_strobe = psel && penable && pwrite;
    assign reg_sel   = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_strobe)
        begin
            case (reg_sel)
                pfr_pkg::REG_FORMAT:     cfg_next.pixel_format   = pwdata[1:0];
                pfr_pkg::REG_VIS_WIDTH:  cfg_next.visible_width  = pwdata[12:0];
                pfr_pkg::REG_VIS_HEIGHT: cfg_next.visible_height = pwdata[12:0];
                pfr_pkg::REG_ROW_PITCH:  cfg_next.row_pitch      = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            pfr_pkg::REG_FORMAT:     prdata = {30'd0, cfg_reg.pixel_format};
            pfr_pkg::REG_VIS_WIDTH:  prdata = {19'd0, cfg_reg.visible_width};
            pfr_pkg::REG_VIS_HEIGHT: prdata = {19'd0, cfg_reg.visible_height};
            pfr_pkg::REG_ROW_PITCH:  prdata = {16'd0, cfg_reg.row_pitch};
            default:                 prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_palette.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One write and one registered read per cycle. Contents undefined until written.
module pfr_palette (
    input  wire logic              clk,
    input  wire pfr_pkg::pal_req_t req,
    output logic [31:0]            rd_data
);

    logic [31:0] mem [pfr_pkg::PAL_ENTRIES];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_slot] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pfr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Four-stage conversion pipeline:
//   S1 capture + palette read, S2 products, S3 /1000 + address add, S4 clamp/select.
module pfr_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pfr_pkg::cfg_t          cfg,
    pfr_pix_if.sink                     pixel,
    pfr_res_if.source                   result,
    output pfr_pkg::pal_req_t           pal_req,
    input  wire logic [31:0]            pal_rd_data,
    output pfr_pkg::pipe_status_t       status
);

    localparam logic [8:0] PAL_LIMIT = 9'(pfr_pkg::PAL_ENTRIES);

    // floor(p / 1000) by reciprocal multiply, exact over the product range
    function automatic logic [7:0] div_1000(input logic [17:0] p);
        logic [36:0] prod;
        prod = 37'(p) * 37'(pfr_pkg::RECIP_1000);
        return prod[pfr_pkg::RECIP_SHIFT+7:pfr_pkg::RECIP_SHIFT];
    endfunction

    function automatic logic signed [10:0] apply_sign(input logic neg, input logic [7:0] q);
        logic signed [10:0] v;
        v = $signed({3'b000, q});
        return neg ? -v : v;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [10:0] v);
        logic [7:0] c;
        if (v < 0)
            c = 8'd0;
        else if (v > 11'sd255)
            c = 8'd255;
        else
            c = v[7:0];
        return c;
    endfunction

    // handshake chain
    logic adv1, adv2, adv3, adv4;
    logic accept;
    logic keep;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // S1
    logic [11:0] s1_col_reg;
    logic [11:0] s1_row_reg;
    logic [7:0]  s1_luma_reg;
    logic [7:0]  s1_cb_mag_reg, s1_cr_mag_reg;
    logic        s1_cb_neg_reg, s1_cr_neg_reg;
    logic [1:0]  s1_fmt_reg;
    logic [14:0] s1_555_reg;
    logic        s1_idx_ok_reg;
    logic [7:0]  cb_mag_next, cr_mag_next;

    // S2
    logic [11:0] s2_col_reg;
    logic [27:0] s2_addr_prod_reg;
    logic [7:0]  s2_luma_reg;
    logic [17:0] s2_pr_reg, s2_pgb_reg, s2_pgr_reg, s2_pb_reg;
    logic        s2_cb_neg_reg, s2_cr_neg_reg;
    logic [1:0]  s2_fmt_reg;
    logic [14:0] s2_555_reg;
    logic [31:0] s2_pal_reg;

    // S3
    logic [27:0] s3_addr_reg;
    logic [7:0]  s3_luma_reg;
    logic [7:0]  s3_qr_reg, s3_qgb_reg, s3_qgr_reg, s3_qb_reg;
    logic        s3_cb_neg_reg, s3_cr_neg_reg;
    logic [1:0]  s3_fmt_reg;
    logic [14:0] s3_555_reg;
    logic [31:0] s3_pal_reg;

    // S4 / output
    logic [27:0]        out_addr_reg;
    logic [31:0]        out_rgb_reg;
    logic [31:0]        rgb_next;
    logic signed [10:0] y_s, r_sum, g_sum, b_sum;

    assign adv4 = !v4_reg || result.ready;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;

    assign pixel.ready = adv1;
    assign accept      = pixel.valid && adv1;

    assign keep = accept && (pixel.cmd == pfr_pkg::CMD_PIXEL)
               && ({1'b0, pixel.col} < cfg.visible_width)
               && ({1'b0, pixel.row_index} < cfg.visible_height)
               && ((cfg.pixel_format == pfr_pkg::FMT_YCBCR)
                   || (cfg.pixel_format == pfr_pkg::FMT_PAL8)
                   || (cfg.pixel_format == pfr_pkg::FMT_RGB555));

    // palette port: load items write, every S1 load reads
    assign pal_req.wr_en   = accept && (pixel.cmd == pfr_pkg::CMD_LOAD)
                          && ({1'b0, pixel.palette_slot} < PAL_LIMIT);
    assign pal_req.wr_slot = pixel.palette_slot[pfr_pkg::PAL_AW-1:0];
    assign pal_req.wr_data = pixel.palette_value;
    assign pal_req.rd_en   = adv1;
    assign pal_req.rd_idx  = pixel.color_index[pfr_pkg::PAL_AW-1:0];

    // chroma magnitude around 128
    assign cb_mag_next = pixel.chroma_blue[7] ? {1'b0, pixel.chroma_blue[6:0]}
                                              : 8'(pfr_pkg::CHROMA_MID - {1'b0, pixel.chroma_blue});
    assign cr_mag_next = pixel.chroma_red[7] ? {1'b0, pixel.chroma_red[6:0]}
                                             : 8'(pfr_pkg::CHROMA_MID - {1'b0, pixel.chroma_red});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= keep;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // S1
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_col_reg    <= pixel.col;
            s1_row_reg    <= pixel.row_index;
            s1_luma_reg   <= pixel.luma;
            s1_cb_mag_reg <= cb_mag_next;
            s1_cr_mag_reg <= cr_mag_next;
            s1_cb_neg_reg <= !pixel.chroma_blue[7];
            s1_cr_neg_reg <= !pixel.chroma_red[7];
            s1_fmt_reg    <= cfg.pixel_format;
            s1_555_reg    <= pixel.packed_555[14:0];
            s1_idx_ok_reg <= ({1'b0, pixel.color_index} < PAL_LIMIT);
        end
    end

    // S2
    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_col_reg       <= s1_col_reg;
            s2_addr_prod_reg <= 28'(s1_row_reg) * 28'(cfg.row_pitch);
            s2_luma_reg      <= s1_luma_reg;
            s2_pr_reg        <= 18'(s1_cr_mag_reg) * 18'(pfr_pkg::COEF_R_CR);
            s2_pgb_reg       <= 18'(s1_cb_mag_reg) * 18'(pfr_pkg::COEF_G_CB);
            s2_pgr_reg       <= 18'(s1_cr_mag_reg) * 18'(pfr_pkg::COEF_G_CR);
            s2_pb_reg        <= 18'(s1_cb_mag_reg) * 18'(pfr_pkg::COEF_B_CB);
            s2_cb_neg_reg    <= s1_cb_neg_reg;
            s2_cr_neg_reg    <= s1_cr_neg_reg;
            s2_fmt_reg       <= s1_fmt_reg;
            s2_555_reg       <= s1_555_reg;
            s2_pal_reg       <= s1_idx_ok_reg ? pal_rd_data : 32'd0;
        end
    end

    // S3
    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_addr_reg   <= s2_addr_prod_reg + 28'(s2_col_reg);
            s3_luma_reg   <= s2_luma_reg;
            s3_qr_reg     <= div_1000(s2_pr_reg);
            s3_qgb_reg    <= div_1000(s2_pgb_reg);
            s3_qgr_reg    <= div_1000(s2_pgr_reg);
            s3_qb_reg     <= div_1000(s2_pb_reg);
            s3_cb_neg_reg <= s2_cb_neg_reg;
            s3_cr_neg_reg <= s2_cr_neg_reg;
            s3_fmt_reg    <= s2_fmt_reg;
            s3_555_reg    <= s2_555_reg;
            s3_pal_reg    <= s2_pal_reg;
        end
    end

    // S4: channel sums, clamp and format select
    assign y_s   = $signed({3'b000, s3_luma_reg});
    assign r_sum = y_s + apply_sign(s3_cr_neg_reg, s3_qr_reg);
    assign g_sum = y_s - apply_sign(s3_cb_neg_reg, s3_qgb_reg)
                       - apply_sign(s3_cr_neg_reg, s3_qgr_reg);
    assign b_sum = y_s + apply_sign(s3_cb_neg_reg, s3_qb_reg);

    always_comb
    begin
        case (s3_fmt_reg)
            pfr_pkg::FMT_YCBCR:  rgb_next = {8'd0, clamp8(r_sum), clamp8(g_sum), clamp8(b_sum)};
            pfr_pkg::FMT_PAL8:   rgb_next = s3_pal_reg;
            pfr_pkg::FMT_RGB555: rgb_next = {8'd0, s3_555_reg[14:10], 3'b000,
                                             s3_555_reg[9:5], 3'b000,
                                             s3_555_reg[4:0], 3'b000};
            default:             rgb_next = 32'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            out_addr_reg <= s3_addr_reg;
            out_rgb_reg  <= rgb_next;
        end
    end

    assign result.valid        = v4_reg;
    assign result.dest_address = out_addr_reg;
    assign result.rgb_word     = out_rgb_reg;

    assign status.s1_valid = v1_reg;
    assign status.s2_valid = v2_reg;
    assign status.s3_valid = v3_reg;
    assign status.s4_valid = v4_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_format_to_rgb_unit.sv =====
// Pixel format to RGB converter, one source pixel per transfer.
// Four register stages: capture/palette read, products, /1000 and address add, clamp.
// Throughput: one pixel per cycle unless result back-pressure stalls the pipe;
// the palette memory reads and writes at most once per cycle.
// Reset (rst_n, async active low) clears stage valids and config; palette is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "pixel_format_to_rgb_unit_defines.svh"

module pixel_format_to_rgb_unit (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // APB config port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [pfr_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    // streams
    pfr_pix_if.sink                         pixel,
    pfr_res_if.source                       result
);

    pfr_pkg::cfg_t         cfg;
    pfr_pkg::pal_req_t     pal_req;
    pfr_pkg::pipe_status_t status;
    logic [31:0]           pal_rd_data;

    // Zero-wait-state slave; user writes config only with pipeline drained (not enforced).
    assign pready = 1'b1;

    pfr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Palette: load transfers write at the accepting edge; the read for a pixel
    // happens at that same edge, so a load is seen by the very next pixel.
    pfr_palette u_pal (
        .clk     (clk),
        .req     (pal_req),
        .rd_data (pal_rd_data)
    );

    // Pipeline: each stage loads when it is empty or the next stage moves,
    // so bubbles collapse and input is taken while a result waits at the output.
    // Load transfers, pixels outside the window and the unused format never
    // enter as valid and so produce no result transfer.
    pfr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel       (pixel),
        .result      (result),
        .pal_req     (pal_req),
        .pal_rd_data (pal_rd_data),
        .status      (status)
    );

    // An empty output stage means every stage can move, so input must be open.
    `PFR_ASSERT_IMP(a_ready_when_out_empty, !result.valid, pixel.ready)

    // A palette load never creates a pipeline item.
    `PFR_ASSERT_NXT(a_load_no_item,
        pixel.valid && pixel.ready && (pixel.cmd == pfr_pkg::CMD_LOAD), !status.s1_valid)

    // An item in S3 with an empty output stage always moves forward.
    `PFR_ASSERT_NXT(a_s3_advances, status.s3_valid && !status.s4_valid, status.s4_valid)

endmodule

`default_nettype wire

// ===== dv/pfr_test_pkg.sv =====
`timescale 1ns / 1ps

package pfr_test_pkg;
    import pfr_pkg::*;

    localparam int         RATIO_DIV  = 1000;
    localparam logic [1:0] FMT_UNUSED = 2'd3;

    typedef struct {
        logic        cmd;
        logic [11:0] col;
        logic [11:0] row_index;
        logic [7:0]  luma;
        logic [7:0]  chroma_blue;
        logic [7:0]  chroma_red;
        logic [7:0]  color_index;
        logic [15:0] packed_555;
        logic [7:0]  palette_slot;
        logic [31:0] palette_value;
    } pix_item_t;

    typedef struct {
        logic [27:0] dest_address;
        logic [31:0] rgb_word;
    } rgb_result_t;

    // Tracks config and palette, predicts each converted pixel, checks results in order.
    class pixel_result_tracker;
        cfg_t        cfg;
        logic [31:0] palette [PAL_ENTRIES];
        rgb_result_t awaited [$];
        int          errors;

        function new();
            cfg    = '0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FORMAT:     cfg.pixel_format   = value[1:0];
                REG_VIS_WIDTH:  cfg.visible_width  = value[12:0];
                REG_VIS_HEIGHT: cfg.visible_height = value[12:0];
                REG_ROW_PITCH:  cfg.row_pitch      = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] clamp_channel(int v);
            if (v < 0)
                return 8'd0;
            if (v > 255)
                return 8'd255;
            return v[7:0];
        endfunction

        // Signed int division truncates toward zero, as the conversion requires.
        function logic [31:0] ycbcr_to_rgb(logic [7:0] y8, logic [7:0] cb8, logic [7:0] cr8);
            int y;
            int cb;
            int cr;
            logic [7:0] r;
            logic [7:0] g;
            logic [7:0] b;
            y  = int'(y8);
            cb = int'(cb8) - int'(CHROMA_MID);
            cr = int'(cr8) - int'(CHROMA_MID);
            r  = clamp_channel(y + (cr * int'(COEF_R_CR)) / RATIO_DIV);
            g  = clamp_channel(y - (cb * int'(COEF_G_CB)) / RATIO_DIV
                                 - (cr * int'(COEF_G_CR)) / RATIO_DIV);
            b  = clamp_channel(y + (cb * int'(COEF_B_CB)) / RATIO_DIV);
            return {8'h00, r, g, b};
        endfunction

        function void take_transfer(pix_item_t it);
            rgb_result_t res;
            logic [39:0] addr;
            if (it.cmd == CMD_LOAD)
            begin
                palette[it.palette_slot] = it.palette_value;
                return;
            end
            if (it.col >= cfg.visible_width || it.row_index >= cfg.visible_height)
                return;
            case (cfg.pixel_format)
                FMT_YCBCR:  res.rgb_word = ycbcr_to_rgb(it.luma, it.chroma_blue, it.chroma_red);
                FMT_PAL8:   res.rgb_word = palette[it.color_index];
                FMT_RGB555: res.rgb_word = {8'h00, it.packed_555[14:10], 3'b000,
                                            it.packed_555[9:5], 3'b000,
                                            it.packed_555[4:0], 3'b000};
                default:    return;
            endcase
            addr = 40'(it.row_index) * 40'(cfg.row_pitch) + 40'(it.col);
            res.dest_address = addr[27:0];
            awaited.push_back(res);
        endfunction

        function void match_result(logic [27:0] addr, logic [31:0] rgb);
            rgb_result_t want;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: dest_address %0h rgb_word %08h", addr, rgb);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (addr !== want.dest_address)
            begin
                $error("dest_address expected %0h actual %0h", want.dest_address, addr);
                errors++;
            end
            if (rgb !== want.rgb_word)
            begin
                $error("rgb_word expected %08h actual %08h", want.rgb_word, rgb);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== dv/pixel_format_to_rgb_unit_test.sv =====
`timescale 1ns / 1ps

module pixel_format_to_rgb_unit_test;
    import pfr_pkg::*;
    import pfr_test_pkg::*;

    // Receiver hold-off used to back the pipe up into the pixel input.
    localparam int unsigned HOLD_CYCLES = 400;
    // Settling time after the last expected result; pipe is 4 stages deep.
    localparam int          DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    pfr_pix_if pixel_bus ();
    pfr_res_if result_bus ();

    pixel_result_tracker tracker = new();
    pix_item_t           seen_item;

    // Idle/stall rates in percent; the hold counter pair hands a long stall to the receiver.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned holds_served   = 0;
    int unsigned hold_left      = 0;

    pixel_format_to_rgb_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pixel   (pixel_bus),
        .result  (result_bus)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result side: random stall, or a long hold-off when the stimulus asks for one.
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served     <= hold_requests;
            hold_left        <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left        <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else
        begin
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: both channels are sampled at the edge, before any new drive lands.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                seen_item.cmd           = pixel_bus.cmd;
                seen_item.col           = pixel_bus.col;
                seen_item.row_index     = pixel_bus.row_index;
                seen_item.luma          = pixel_bus.luma;
                seen_item.chroma_blue   = pixel_bus.chroma_blue;
                seen_item.chroma_red    = pixel_bus.chroma_red;
                seen_item.color_index   = pixel_bus.color_index;
                seen_item.packed_555    = pixel_bus.packed_555;
                seen_item.palette_slot  = pixel_bus.palette_slot;
                seen_item.palette_value = pixel_bus.palette_value;
                tracker.take_transfer(seen_item);
            end
            if (result_bus.valid && result_bus.ready)
                tracker.match_result(result_bus.dest_address, result_bus.rgb_word);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts right after a rising edge and
    // leaves the same way, so each signal sees at most one NBA per step.
    // ------------------------------------------------------------------

    // One APB transfer: setup, access, wait for pready.
    task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write a register, keep the predictor in step, then read it back.
    task automatic set_register(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] readback;
        apb_cycle(1'b1, idx, value, readback);
        tracker.set_register(idx, value);
        apb_cycle(1'b0, idx, 32'h0, readback);
        if (readback !== value)
        begin
            $error("register %0d readback expected %0h actual %0h", idx, value, readback);
            tracker.errors++;
        end
    endtask

    // Offer one pixel transfer after a random gap; valid stays up after the handshake
    // so back-to-back transfers need no second assignment in the same step.
    task automatic send_item(input pix_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_bus.valid         <= 1'b1;
        pixel_bus.cmd           <= it.cmd;
        pixel_bus.col           <= it.col;
        pixel_bus.row_index     <= it.row_index;
        pixel_bus.luma          <= it.luma;
        pixel_bus.chroma_blue   <= it.chroma_blue;
        pixel_bus.chroma_red    <= it.chroma_red;
        pixel_bus.color_index   <= it.color_index;
        pixel_bus.packed_555    <= it.packed_555;
        pixel_bus.palette_slot  <= it.palette_slot;
        pixel_bus.palette_value <= it.palette_value;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every awaited result, then let dropped pixels clear the pipe.
    task automatic settle();
        pixel_bus.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random payload in every field, so unused fields toggle too.
    function automatic pix_item_t random_fields();
        pix_item_t it;
        it.cmd           = CMD_PIXEL;
        it.col           = 12'($urandom_range(4095));
        it.row_index     = 12'($urandom_range(4095));
        it.luma          = 8'($urandom_range(255));
        it.chroma_blue   = 8'($urandom_range(255));
        it.chroma_red    = 8'($urandom_range(255));
        it.color_index   = 8'($urandom_range(255));
        it.packed_555    = 16'($urandom_range(65535));
        it.palette_slot  = 8'($urandom_range(255));
        it.palette_value = $urandom;
        return it;
    endfunction

    // Coordinate mostly inside the window, with its last column/row and the
    // first one past it weighted up.
    function automatic logic [11:0] pick_coord(input int unsigned limit);
        int unsigned r;
        r = $urandom_range(99);
        if (limit == 0 || r >= 92)
            return 12'($urandom_range(4095));
        if (r < 75)
            return 12'($urandom_range(limit - 1));
        if (r < 85 || limit > 4095)
            return 12'(limit - 1);
        return 12'(limit);
    endfunction

    // Samples lean toward the clamp and zero-chroma corners.
    function automatic logic [7:0] pick_sample();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_load(input logic [7:0] slot, input logic [31:0] value);
        pix_item_t it;
        it               = random_fields();
        it.cmd           = CMD_LOAD;
        it.palette_slot  = slot;
        it.palette_value = value;
        send_item(it);
    endtask

    task automatic send_ycbcr(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
                              input logic [11:0] col, input logic [11:0] row);
        pix_item_t it;
        it             = random_fields();
        it.luma        = y;
        it.chroma_blue = cb;
        it.chroma_red  = cr;
        it.col         = col;
        it.row_index   = row;
        send_item(it);
    endtask

    task automatic send_index(input logic [7:0] idx);
        pix_item_t it;
        it             = random_fields();
        it.color_index = idx;
        send_item(it);
    endtask

    task automatic send_555(input logic [15:0] raw);
        pix_item_t it;
        it            = random_fields();
        it.packed_555 = raw;
        send_item(it);
    endtask

    // One configuration phase: program the window, set idling, then stream
    // random pixels with loads mixed in. In palette mode a load is often
    // followed next by a read of the same slot to exercise write-then-read.
    task automatic run_phase(input logic [1:0] fmt, input int unsigned w, input int unsigned h,
                             input int unsigned pitch, input int unsigned send_pct,
                             input int unsigned recv_pct, input int unsigned count,
                             input bit long_hold);
        pix_item_t   it;
        int unsigned sent;
        int unsigned r;
        settle();
        set_register(REG_FORMAT, 32'(fmt));
        set_register(REG_VIS_WIDTH, w);
        set_register(REG_VIS_HEIGHT, h);
        set_register(REG_ROW_PITCH, pitch);
        send_idle_pct  =  send_pct;
        recv_stall_pct <= recv_pct;
        if (long_hold)
            hold_requests <= hold_requests + 1;
        sent = 0;
        while (sent < count)
        begin
            r  = $urandom_range(99);
            it = random_fields();
            if (r < 10)
            begin
                it.cmd = CMD_LOAD;
                send_item(it);
                sent++;
            end
            else if (r < 20 && fmt == FMT_PAL8 && w != 0 && h != 0)
            begin
                send_load(it.palette_slot, it.palette_value);
                it.color_index = it.palette_slot;
                it.col         = 12'($urandom_range(w - 1));
                it.row_index   = 12'($urandom_range(h - 1));
                send_item(it);
                sent += 2;
            end
            else
            begin
                it.col         = pick_coord(w);
                it.row_index   = pick_coord(h);
                it.luma        = pick_sample();
                it.chroma_blue = pick_sample();
                it.chroma_red  = pick_sample();
                send_item(it);
                sent++;
            end
        end
    endtask

    initial
    begin
        // Known values on every input before the first edge.
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        pixel_bus.valid         = 1'b0;
        pixel_bus.cmd           = CMD_PIXEL;
        pixel_bus.col           = '0;
        pixel_bus.row_index     = '0;
        pixel_bus.luma          = '0;
        pixel_bus.chroma_blue   = '0;
        pixel_bus.chroma_red    = '0;
        pixel_bus.color_index   = '0;
        pixel_bus.packed_555    = '0;
        pixel_bus.palette_slot  = '0;
        pixel_bus.palette_value = '0;
        result_bus.ready        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The palette powers up undefined: fill every slot before any palette
        // lookup can happen, even one whose pixel is later dropped.
        for (int slot = 0; slot < PAL_ENTRIES; slot++)
            send_load(8'(slot), $urandom);

        // Directed: YCbCr corners, clamping both ways, and quotients where
        // truncation toward zero differs from floor.
        settle();
        set_register(REG_FORMAT, 32'(FMT_YCBCR));
        set_register(REG_VIS_WIDTH, 4096);
        set_register(REG_VIS_HEIGHT, 4096);
        set_register(REG_ROW_PITCH, 65535);
        send_ycbcr(8'd0,   8'd128, 8'd128, 12'd0,    12'd0);
        send_ycbcr(8'd255, 8'd128, 8'd128, 12'd4095, 12'd4095);
        send_ycbcr(8'd0,   8'd0,   8'd0,   12'd1,    12'd0);
        send_ycbcr(8'd255, 8'd255, 8'd255, 12'd0,    12'd1);
        send_ycbcr(8'd255, 8'd0,   8'd255, 12'd4095, 12'd0);
        send_ycbcr(8'd0,   8'd255, 8'd0,   12'd0,    12'd4095);
        send_ycbcr(8'd230, 8'd0,   8'd128, 12'd2048, 12'd1024);
        send_ycbcr(8'd180, 8'd128, 8'd0,   12'd1365, 12'd2730);

        // Directed: palette load immediately followed by a read of that slot.
        settle();
        set_register(REG_FORMAT, 32'(FMT_PAL8));
        send_load(8'd0, 32'h0000_0000);
        send_index(8'd0);
        send_load(8'd255, 32'hffff_ffff);
        send_index(8'd255);
        send_index(8'd255);
        send_load(8'd170, 32'h55a5_a5a5);
        send_index(8'd170);

        // Directed: RGB555 field placement; the top bit must be ignored.
        settle();
        set_register(REG_FORMAT, 32'(FMT_RGB555));
        send_555(16'hffff);
        send_555(16'h7fff);
        send_555(16'h8000);
        send_555(16'h0000);
        send_555(16'h7c00);
        send_555(16'h03e0);
        send_555(16'h001f);

        // Random phases. The first one holds the receiver off while the
        // sender keeps going, so the pipe fills and stalls the pixel input.
        run_phase(FMT_YCBCR,  4096, 4096, 65535,  0,  0, 150, 1'b1);
        run_phase(FMT_PAL8,   64,   32,   640,   59,  0, 140, 1'b0);
        run_phase(FMT_RGB555, 4096, 4096, 0,      0, 59, 140, 1'b0);
        run_phase(FMT_YCBCR,  17,   9,    17,    29, 29, 130, 1'b0);
        run_phase(FMT_PAL8,   4096, 4096, 65535,  0,  0, 130, 1'b0);
        run_phase(FMT_UNUSED, 100,  100,  100,   29, 29,  50, 1'b0);
        run_phase(FMT_RGB555, 0,    0,    1234,  59,  0,  40, 1'b0);
        run_phase(FMT_YCBCR,  1,    1,    1,      0, 59,  60, 1'b0);
        run_phase(FMT_PAL8,   300,  200,  300,   29, 29,  40, 1'b0);

        settle();
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
